// File: hdl/bvtam_pkg.sv
package bvtam_pkg;

   localparam int SAMPLE_W = 16;
   localparam int WHOLE_W  = 13;

   localparam int DIV10_SHIFT = 20;
   localparam logic [16:0] DIV10_MULT = 17'd104858;

   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_CHECK   = 2'd1,
      OP_PRELOAD = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_GAIN       = 3'd0,
      REG_LOW_LIMIT  = 3'd1,
      REG_HIGH_LIMIT = 3'd2,
      REG_LOW_DELAY  = 3'd3,
      REG_OVER_DELAY = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_LOAD
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type        cmd;
      logic [SAMPLE_W-1:0] fill;
   } cell_ctrl_type;

   typedef struct packed {
      logic enable;
      logic first;
   } acc_ctrl_type;

endpackage

// File: hdl/bvtam_cell.sv
module bvtam_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  bvtam_pkg::cell_ctrl_type         ctrl,
   input  logic [bvtam_pkg::SAMPLE_W-1:0]   neighbor,
   output logic [bvtam_pkg::SAMPLE_W-1:0]   value
);

   logic [bvtam_pkg::SAMPLE_W-1:0] value_ff;
   logic [bvtam_pkg::SAMPLE_W-1:0] value_in;

   always_comb begin
      case (ctrl.cmd)
         bvtam_pkg::CELL_SHIFT: value_in = neighbor;
         bvtam_pkg::CELL_LOAD:  value_in = ctrl.fill;
         default:               value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// File: hdl/bvtam_trim_acc.sv
module bvtam_trim_acc #(
   parameter int SUM_W = 19
) (
   input  logic                             clock,
   input  bvtam_pkg::acc_ctrl_type          ctrl,
   input  logic [bvtam_pkg::SAMPLE_W-1:0]   value,
   output logic [SUM_W-1:0]                 sum,
   output logic [bvtam_pkg::SAMPLE_W-1:0]   lo,
   output logic [bvtam_pkg::SAMPLE_W-1:0]   hi
);

   logic [SUM_W-1:0]               sum_ff;
   logic [bvtam_pkg::SAMPLE_W-1:0] lo_ff;
   logic [bvtam_pkg::SAMPLE_W-1:0] hi_ff;

   always_ff @(posedge clock) begin
      if (ctrl.enable) begin
         if (ctrl.first) begin
            sum_ff <= SUM_W'(value);
            lo_ff  <= value;
            hi_ff  <= value;
         end else begin
            sum_ff <= sum_ff + SUM_W'(value);
            if (value < lo_ff) begin
               lo_ff <= value;
            end
            if (value > hi_ff) begin
               hi_ff <= value;
            end
         end
      end
   end

   assign sum = sum_ff;
   assign lo  = lo_ff;
   assign hi  = hi_ff;

endmodule

// File: hdl/bus_voltage_trimmed_avg_monitor_unit.sv
// Bus voltage monitor with a trimmed moving average over a ring of samples.
// Request channel (req_valid/req_ready) carries an op and an ADC code:
//   op 0 converts the code, pushes it into the ring and recomputes the
//   average with the smallest and largest entries dropped; op 1 checks the
//   stored average against the limits and updates the fault flags; op 2
//   fills the whole ring with the converted code; op 3 changes nothing.
// Every request returns one response transaction on rsp_valid/rsp_ready.
// The ring is a chain of cells; a new sample shifts in at the head, then the
// chain rotates once while the accumulator at the tail gathers sum, minimum
// and maximum, one entry per cycle.
// States from acceptance: a sample MUL, CONV, SCAN, TRIM, QMUL, QOUT, FINISH; a
// preload MUL, CONV, FINISH; a check CHECK, FINISH; op 3 FINISH. One request is in
// flight at a time; req_ready is high only while idle.
// Reset clears the ring, the average, the flags and counters, drops any
// pending response and returns the configuration registers to their defaults.
// A stalled response holds in the output register; the next request is
// accepted meanwhile and waits to finish until the register is taken.
module bus_voltage_trimmed_avg_monitor_unit #(
   parameter int RING_DEPTH = 8,
   parameter int ADC_WIDTH  = 12
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   input  logic [ADC_WIDTH-1:0]   req_adc_code,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_volts_tenths,
   output logic [12:0]            rsp_volts_whole,
   output logic [15:0]            rsp_avg_tenths,
   output logic [12:0]            rsp_avg_whole,
   output logic                   rsp_over_fault,
   output logic                   rsp_under_fault,

   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [4:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int SW       = bvtam_pkg::SAMPLE_W;
   localparam int SUM_W    = SW + $clog2(RING_DEPTH);
   localparam int CNT_W    = $clog2(RING_DEPTH);
   localparam int TRIM_DIV = RING_DEPTH - 2;
   localparam int TRIM_L   = $clog2(TRIM_DIV);
   localparam int TRIM_SH  = SUM_W + TRIM_L;
   localparam logic [SUM_W:0] TRIM_MULT =
      (SUM_W+1)'(((64'd1 << TRIM_SH) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV));

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_CONV,
      ST_SCAN,
      ST_TRIM,
      ST_QMUL,
      ST_QOUT,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type state_ff;

   logic [23:0] gain_ff;
   logic [15:0] low_limit_ff;
   logic [15:0] high_limit_ff;
   logic [15:0] low_delay_ff;
   logic [15:0] over_delay_ff;

   logic [1:0]            op_ff;
   logic [ADC_WIDTH-1:0]  code_ff;
   logic [SW-1:0]         conv_ff;
   logic [SW-1:0]         last_ff;
   logic [SW-1:0]         avg_ff;
   logic [CNT_W-1:0]      scan_cnt_ff;
   logic [SUM_W-1:0]      trim_ff;
   logic [2*SUM_W:0]      qprod_ff;
   logic                  over_ff;
   logic                  under_ff;
   logic [16:0]           under_cnt_ff;
   logic [15:0]           over_hold_ff;

   logic                  rsp_valid_ff;
   logic [15:0]           rsp_volts_tenths_ff;
   logic [12:0]           rsp_volts_whole_ff;
   logic [15:0]           rsp_avg_tenths_ff;
   logic [12:0]           rsp_avg_whole_ff;
   logic                  rsp_over_ff;
   logic                  rsp_under_ff;

   logic [23+ADC_WIDTH:0] prod;
   logic [32:0]           last_div10;
   logic [32:0]           avg_div10;

   logic                  over_in;
   logic                  under_in;
   logic [16:0]           under_cnt_in;
   logic [16:0]           under_inc;
   logic [15:0]           over_hold_in;

   bvtam_pkg::cell_ctrl_type cell_ctrl;
   bvtam_pkg::acc_ctrl_type  acc_ctrl;
   logic [SW-1:0]            head_in;
   logic [SW-1:0]            cell_q [RING_DEPTH];
   logic [SUM_W-1:0]         acc_sum;
   logic [SW-1:0]            acc_lo;
   logic [SW-1:0]            acc_hi;

   logic                  csr_write;
   logic                  rsp_free;

   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (paddr[4:2])
         bvtam_pkg::REG_GAIN:       prdata = {8'd0, gain_ff};
         bvtam_pkg::REG_LOW_LIMIT:  prdata = {16'd0, low_limit_ff};
         bvtam_pkg::REG_HIGH_LIMIT: prdata = {16'd0, high_limit_ff};
         bvtam_pkg::REG_LOW_DELAY:  prdata = {16'd0, low_delay_ff};
         bvtam_pkg::REG_OVER_DELAY: prdata = {16'd0, over_delay_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   assign prod       = gain_ff * code_ff;
   assign last_div10 = last_ff * bvtam_pkg::DIV10_MULT;
   assign avg_div10  = avg_ff * bvtam_pkg::DIV10_MULT;

   always_comb begin
      over_in      = over_ff;
      under_in     = under_ff;
      under_cnt_in = under_cnt_ff;
      over_hold_in = over_hold_ff;
      under_inc    = (under_cnt_ff == '1) ? under_cnt_ff : under_cnt_ff + 17'd1;
      if (avg_ff > high_limit_ff) begin
         over_in      = 1'b1;
         over_hold_in = over_delay_ff;
      end else if (avg_ff < low_limit_ff) begin
         if (under_cnt_ff == 17'd0) begin
            under_in = 1'b1;
         end
         if (under_inc > {1'b0, low_delay_ff}) begin
            under_in = 1'b1;
         end
         under_cnt_in = under_inc;
      end else begin
         under_cnt_in = 17'd1;
         if (over_hold_ff != 16'd0) begin
            over_hold_in = over_hold_ff - 16'd1;
         end else begin
            over_in = 1'b0;
         end
      end
   end

   always_comb begin
      cell_ctrl.cmd  = bvtam_pkg::CELL_HOLD;
      cell_ctrl.fill = conv_ff;
      head_in        = cell_q[RING_DEPTH-1];
      acc_ctrl.enable = (state_ff == ST_SCAN);
      acc_ctrl.first  = (scan_cnt_ff == '0);
      case (state_ff)
         ST_CONV: begin
            if (op_ff == bvtam_pkg::OP_PRELOAD) begin
               cell_ctrl.cmd = bvtam_pkg::CELL_LOAD;
            end else begin
               cell_ctrl.cmd = bvtam_pkg::CELL_SHIFT;
               head_in       = conv_ff;
            end
         end
         ST_SCAN: cell_ctrl.cmd = bvtam_pkg::CELL_SHIFT;
         default: cell_ctrl.cmd = bvtam_pkg::CELL_HOLD;
      endcase
   end

   for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
      bvtam_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .neighbor ((i == 0) ? head_in : cell_q[(i == 0) ? 0 : i-1]),
         .value    (cell_q[i])
      );
   end

   bvtam_trim_acc #(
      .SUM_W (SUM_W)
   ) u_acc (
      .clock (clock),
      .ctrl  (acc_ctrl),
      .value (cell_q[RING_DEPTH-1]),
      .sum   (acc_sum),
      .lo    (acc_lo),
      .hi    (acc_hi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= '0;
         low_limit_ff  <= '0;
         high_limit_ff <= 16'hFFFF;
         low_delay_ff  <= '0;
         over_delay_ff <= '0;
      end else if (csr_write) begin
         case (paddr[4:2])
            bvtam_pkg::REG_GAIN:       gain_ff       <= pwdata[23:0];
            bvtam_pkg::REG_LOW_LIMIT:  low_limit_ff  <= pwdata[15:0];
            bvtam_pkg::REG_HIGH_LIMIT: high_limit_ff <= pwdata[15:0];
            bvtam_pkg::REG_LOW_DELAY:  low_delay_ff  <= pwdata[15:0];
            bvtam_pkg::REG_OVER_DELAY: over_delay_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         avg_ff       <= '0;
         over_ff      <= 1'b0;
         under_ff     <= 1'b0;
         under_cnt_ff <= '0;
         over_hold_ff <= '0;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff   <= req_op;
                  code_ff <= req_adc_code;
                  if (req_op == bvtam_pkg::OP_SAMPLE || req_op == bvtam_pkg::OP_PRELOAD) begin
                     state_ff <= ST_MUL;
                  end else if (req_op == bvtam_pkg::OP_CHECK) begin
                     state_ff <= ST_CHECK;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_MUL: begin
               conv_ff  <= prod[31:16];
               state_ff <= ST_CONV;
            end
            ST_CONV: begin
               last_ff     <= conv_ff;
               scan_cnt_ff <= '0;
               state_ff    <= (op_ff == bvtam_pkg::OP_PRELOAD) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN: begin
               scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
               if (scan_cnt_ff == CNT_W'(RING_DEPTH - 1)) begin
                  state_ff <= ST_TRIM;
               end
            end
            ST_TRIM: begin
               trim_ff  <= acc_sum - SUM_W'(acc_lo) - SUM_W'(acc_hi);
               state_ff <= ST_QMUL;
            end
            ST_QMUL: begin
               qprod_ff <= trim_ff * TRIM_MULT;
               state_ff <= ST_QOUT;
            end
            ST_QOUT: begin
               avg_ff   <= qprod_ff[TRIM_SH +: SW];
               state_ff <= ST_FINISH;
            end
            ST_CHECK: begin
               over_ff      <= over_in;
               under_ff     <= under_in;
               under_cnt_ff <= under_cnt_in;
               over_hold_ff <= over_hold_in;
               state_ff     <= ST_FINISH;
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_volts_tenths_ff <= last_ff;
                  rsp_volts_whole_ff  <= last_div10[bvtam_pkg::DIV10_SHIFT +:
                                                    bvtam_pkg::WHOLE_W];
                  rsp_avg_tenths_ff   <= avg_ff;
                  rsp_avg_whole_ff    <= avg_div10[bvtam_pkg::DIV10_SHIFT +:
                                                   bvtam_pkg::WHOLE_W];
                  rsp_over_ff         <= over_ff;
                  rsp_under_ff        <= under_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_volts_tenths = rsp_volts_tenths_ff;
   assign rsp_volts_whole  = rsp_volts_whole_ff;
   assign rsp_avg_tenths   = rsp_avg_tenths_ff;
   assign rsp_avg_whole    = rsp_avg_whole_ff;
   assign rsp_over_fault   = rsp_over_ff;
   assign rsp_under_fault  = rsp_under_ff;

endmodule
